### design/mfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mfr_pkg;

	localparam int BAND_ROWS   = 8;
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [9:0]  coord_t;
	typedef logic signed [11:0] acc_t;

	typedef enum logic [2:0] {
		OP_PIXEL  = 3'd0,
		OP_LINE   = 3'd1,
		OP_CIRCLE = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4,
		OP_FETCH  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_PIXEL,
		KIND_LINE,
		KIND_CIRCLE,
		KIND_CLEAR,
		KIND_READ,
		KIND_FETCH
	} kind_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PLOT,
		ST_WRITE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] x_start;
		logic [7:0] y_start;
		logic [7:0] x_end;
		logic [7:0] y_end;
		logic [6:0] radius;
		logic       color;
	} cmd_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [6:0] dirty_left;
		logic [6:0] dirty_right;
		logic [5:0] dirty_top;
		logic [5:0] dirty_bottom;
	} rsp_t;

	typedef struct packed {
		kind_t kind;
		cmd_t  cmd;
	} entry_t;

endpackage
`default_nettype wire

### design/monochrome_framebuffer_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// One-bit framebuffer of PANEL_WIDTH x PANEL_HEIGHT pixels stored as one byte per column per
// 8-row band (bit 0 on top) in a single-port-write memory, with a dirty rectangle. Commands
// enter a two-entry queue and run in order on the draw engine, which takes each command from
// the queue in its idle state. Every on-panel pixel is a byte read, then the modified byte
// written back through the one memory port, and an off-panel pixel is skipped without either;
// a line plots max(|dx|,|dy|)+1 steps, and a circle 8 points per midpoint step over about
// 0.71*radius+1 steps. Clear writes one byte a cycle over the whole memory (PANEL_WIDTH *
// ceil(PANEL_HEIGHT/8) bytes, 504 by default); read byte reads the memory, then registers the
// result, and fetch registers the dirty rectangle and empties it as it is taken. After reset
// the same clearing pass runs while cmd_stall stays high. Results wait in an output register
// while later draw commands proceed.
module monochrome_framebuffer_rasterizer #(
	parameter int PANEL_WIDTH  = 84,
	parameter int PANEL_HEIGHT = 48
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire mfr_pkg::cmd_t  cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output mfr_pkg::rsp_t       rsp
);

	logic            q_full, q_valid, push, pop, busy;
	mfr_pkg::entry_t push_entry, head;

	mfr_front u_front (
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.entry     (push_entry)
	);

	mfr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.valid      (q_valid),
		.head       (head)
	);

	mfr_engine #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (head),
		.q_pop     (pop),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

### design/mfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mfr_front (
	input  wire logic           cmd_valid,
	input  wire mfr_pkg::cmd_t  cmd,
	output logic                cmd_stall,
	input  wire logic           q_full,
	input  wire logic           busy,
	output logic                push,
	output mfr_pkg::entry_t     entry
);

	logic keep;

	always_comb begin
		keep = 1'b1;
		entry.cmd = cmd;
		entry.kind = mfr_pkg::KIND_PIXEL;
		unique case (cmd.opcode)
			mfr_pkg::OP_PIXEL:  entry.kind = mfr_pkg::KIND_PIXEL;
			mfr_pkg::OP_LINE:   entry.kind = mfr_pkg::KIND_LINE;
			mfr_pkg::OP_CIRCLE: entry.kind = mfr_pkg::KIND_CIRCLE;
			mfr_pkg::OP_CLEAR:  entry.kind = mfr_pkg::KIND_CLEAR;
			mfr_pkg::OP_READ:   entry.kind = mfr_pkg::KIND_READ;
			mfr_pkg::OP_FETCH:  entry.kind = mfr_pkg::KIND_FETCH;
			default:            keep = 1'b0;
		endcase
	end

	assign cmd_stall = q_full | busy;
	assign push = cmd_valid & ~cmd_stall & keep;

endmodule
`default_nettype wire

### design/mfr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module mfr_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mfr_pkg::entry_t  push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output mfr_pkg::entry_t       head
);

	localparam int PW = $clog2(mfr_pkg::QUEUE_DEPTH);

	mfr_pkg::entry_t mem_q [mfr_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full  = count_q == (PW+1)'(mfr_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule
`default_nettype wire

### design/mfr_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module mfr_engine #(
	parameter int PANEL_WIDTH  = 84,
	parameter int PANEL_HEIGHT = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire mfr_pkg::entry_t  q_head,
	output logic                  q_pop,
	output logic                  busy,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output mfr_pkg::rsp_t         rsp
);

	localparam int BANDS = (PANEL_HEIGHT + mfr_pkg::BAND_ROWS - 1) / mfr_pkg::BAND_ROWS;
	localparam int DEPTH = PANEL_WIDTH * BANDS;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] byte_addr(input logic [7:0] x, input logic [7:0] y);
		return AW'(x) + AW'(y[7:3]) * AW'(PANEL_WIDTH);
	endfunction

	logic [7:0] mem [DEPTH];
	logic [7:0] mem_rd_q;

	mfr_pkg::state_t state_q, state_d;
	logic            init_q;
	logic [AW-1:0]   sweep_q;
	logic            out_valid_q;
	mfr_pkg::rsp_t   out_q;
	logic [7:0]      left_q, right_q, top_q, bottom_q;

	mfr_pkg::kind_t  kind_q;
	logic            color_q;
	mfr_pkg::coord_t cx_q, cy_q, ox_q, oy_q;
	logic [7:0]      xe_q, ye_q;
	mfr_pkg::acc_t   err_q, ldx_q, ldy_q, f_q, ddx_q, ddy_q;
	logic            sx_neg_q, sy_neg_q;
	logic [2:0]      k_q;
	logic [AW-1:0]   waddr_q;
	logic [7:0]      mask_q;
	logic [7:0]      pxw_q, pyw_q;
	logic            rd_hit_q;

	mfr_pkg::coord_t px, py;
	logic            pin, done_c, adv, rd_in;
	logic            mem_re, mem_we;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic [7:0]      wr_data;
	logic [7:0]      adx, ady;
	logic signed [12:0] e2, dx13, dy13;
	logic            step_x, step_y;
	mfr_pkg::acc_t   ddy_n, f_mid;

	always_comb begin
		px = cx_q;
		py = cy_q;
		if (kind_q == mfr_pkg::KIND_CIRCLE) begin
			case (k_q)
				3'd0: begin px = cx_q + ox_q; py = cy_q + oy_q; end
				3'd1: begin px = cx_q - ox_q; py = cy_q + oy_q; end
				3'd2: begin px = cx_q + ox_q; py = cy_q - oy_q; end
				3'd3: begin px = cx_q - ox_q; py = cy_q - oy_q; end
				3'd4: begin px = cx_q + oy_q; py = cy_q + ox_q; end
				3'd5: begin px = cx_q - oy_q; py = cy_q + ox_q; end
				3'd6: begin px = cx_q + oy_q; py = cy_q - ox_q; end
				default: begin px = cx_q - oy_q; py = cy_q - ox_q; end
			endcase
		end
	end

	assign pin = !px[9] && !py[9] && (px < 10'(PANEL_WIDTH)) && (py < 10'(PANEL_HEIGHT));
	assign rd_in = (q_head.cmd.x_start < 8'(PANEL_WIDTH))
		&& ({1'b0, q_head.cmd.y_start} < 9'(PANEL_HEIGHT));

	assign e2   = {err_q, 1'b0};
	assign dx13 = {ldx_q[11], ldx_q};
	assign dy13 = {ldy_q[11], ldy_q};
	assign step_x = e2 >= dy13;
	assign step_y = e2 <= dx13;

	assign ddy_n = f_q[11] ? ddy_q : ddy_q + 12'sd2;
	assign f_mid = f_q[11] ? f_q : f_q + ddy_n;

	always_comb begin
		case (kind_q)
			mfr_pkg::KIND_LINE:
				done_c = (cx_q == {2'b00, xe_q}) && (cy_q == {2'b00, ye_q});
			mfr_pkg::KIND_CIRCLE: done_c = (k_q == 3'd7) && !(ox_q < oy_q);
			default: done_c = 1'b1;
		endcase
	end

	assign adx = (q_head.cmd.x_end > q_head.cmd.x_start) ?
		q_head.cmd.x_end - q_head.cmd.x_start : q_head.cmd.x_start - q_head.cmd.x_end;
	assign ady = (q_head.cmd.y_end > q_head.cmd.y_start) ?
		q_head.cmd.y_end - q_head.cmd.y_start : q_head.cmd.y_start - q_head.cmd.y_end;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfr_pkg::ST_SWEEP:
				if (sweep_q == AW'(DEPTH - 1)) state_d = mfr_pkg::ST_IDLE;
			mfr_pkg::ST_IDLE:
				if (q_pop) begin
					unique case (q_head.kind)
						mfr_pkg::KIND_CLEAR: state_d = mfr_pkg::ST_SWEEP;
						mfr_pkg::KIND_READ:  state_d = mfr_pkg::ST_READ;
						mfr_pkg::KIND_FETCH: state_d = mfr_pkg::ST_IDLE;
						default:             state_d = mfr_pkg::ST_PLOT;
					endcase
				end
			mfr_pkg::ST_PLOT:
				if (pin) state_d = mfr_pkg::ST_WRITE;
				else if (done_c) state_d = mfr_pkg::ST_IDLE;
			mfr_pkg::ST_WRITE:
				state_d = done_c ? mfr_pkg::ST_IDLE : mfr_pkg::ST_PLOT;
			mfr_pkg::ST_READ:
				state_d = mfr_pkg::ST_IDLE;
			default: state_d = mfr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == mfr_pkg::ST_IDLE) && q_valid
			&& ((q_head.kind != mfr_pkg::KIND_READ && q_head.kind != mfr_pkg::KIND_FETCH)
			|| !out_valid_q);
		adv    = ((state_q == mfr_pkg::ST_PLOT) && !pin) || (state_q == mfr_pkg::ST_WRITE);
		mem_re = (q_pop && q_head.kind == mfr_pkg::KIND_READ && rd_in)
			|| ((state_q == mfr_pkg::ST_PLOT) && pin);
		rd_addr = (state_q == mfr_pkg::ST_IDLE) ?
			byte_addr(q_head.cmd.x_start, q_head.cmd.y_start) : byte_addr(px[7:0], py[7:0]);
		mem_we  = (state_q == mfr_pkg::ST_SWEEP) || (state_q == mfr_pkg::ST_WRITE);
		wr_addr = (state_q == mfr_pkg::ST_SWEEP) ? sweep_q : waddr_q;
		if (state_q == mfr_pkg::ST_SWEEP) wr_data = '0;
		else wr_data = color_q ? (mem_rd_q | mask_q) : (mem_rd_q & ~mask_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_re) mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mfr_pkg::ST_SWEEP;
			init_q      <= 1'b1;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
			left_q      <= 8'(PANEL_WIDTH - 1);
			right_q     <= '0;
			top_q       <= 8'(PANEL_HEIGHT - 1);
			bottom_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mfr_pkg::ST_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
				if (sweep_q == AW'(DEPTH - 1)) init_q <= 1'b0;
			end
			if (out_valid_q && !rsp_stall) out_valid_q <= 1'b0;
			if (q_pop) begin
				unique case (q_head.kind)
					mfr_pkg::KIND_CLEAR: begin
						sweep_q  <= '0;
						left_q   <= '0;
						right_q  <= 8'(PANEL_WIDTH - 1);
						top_q    <= '0;
						bottom_q <= 8'(PANEL_HEIGHT - 1);
					end
					mfr_pkg::KIND_FETCH: begin
						out_valid_q <= 1'b1;
						left_q      <= 8'(PANEL_WIDTH - 1);
						right_q     <= '0;
						top_q       <= 8'(PANEL_HEIGHT - 1);
						bottom_q    <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == mfr_pkg::ST_READ) out_valid_q <= 1'b1;
			if (state_q == mfr_pkg::ST_WRITE) begin
				if (pxw_q < left_q) left_q <= pxw_q;
				if (pxw_q > right_q) right_q <= pxw_q;
				if (pyw_q < top_q) top_q <= pyw_q;
				if (pyw_q > bottom_q) bottom_q <= pyw_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q  <= q_head.kind;
			color_q <= q_head.cmd.color;
			cx_q    <= {2'b00, q_head.cmd.x_start};
			cy_q    <= {2'b00, q_head.cmd.y_start};
			xe_q    <= q_head.cmd.x_end;
			ye_q    <= q_head.cmd.y_end;
			rd_hit_q <= rd_in;
			ldx_q   <= $signed({4'b0000, adx});
			ldy_q   <= -$signed({4'b0000, ady});
			err_q   <= $signed({4'b0000, adx}) - $signed({4'b0000, ady});
			sx_neg_q <= !(q_head.cmd.x_start < q_head.cmd.x_end);
			sy_neg_q <= !(q_head.cmd.y_start < q_head.cmd.y_end);
			k_q     <= '0;
			ox_q    <= '0;
			oy_q    <= $signed({3'b000, q_head.cmd.radius});
			f_q     <= 12'sd1 - $signed({5'b00000, q_head.cmd.radius});
			ddx_q   <= 12'sd1;
			ddy_q   <= -$signed({4'b0000, q_head.cmd.radius, 1'b0});
			if (q_head.kind == mfr_pkg::KIND_FETCH) begin
				out_q.byte_value   <= '0;
				out_q.dirty_left   <= left_q[6:0];
				out_q.dirty_right  <= right_q[6:0];
				out_q.dirty_top    <= top_q[5:0];
				out_q.dirty_bottom <= bottom_q[5:0];
			end
		end
		if (state_q == mfr_pkg::ST_READ) begin
			out_q.byte_value   <= rd_hit_q ? mem_rd_q : 8'd0;
			out_q.dirty_left   <= left_q[6:0];
			out_q.dirty_right  <= right_q[6:0];
			out_q.dirty_top    <= top_q[5:0];
			out_q.dirty_bottom <= bottom_q[5:0];
		end
		if (state_q == mfr_pkg::ST_PLOT && pin) begin
			waddr_q <= rd_addr;
			mask_q  <= 8'd1 << py[2:0];
			pxw_q   <= px[7:0];
			pyw_q   <= py[7:0];
		end
		if (adv && !done_c) begin
			if (kind_q == mfr_pkg::KIND_LINE) begin
				err_q <= err_q + (step_x ? ldy_q : 12'sd0) + (step_y ? ldx_q : 12'sd0);
				if (step_x) cx_q <= sx_neg_q ? cx_q - 10'sd1 : cx_q + 10'sd1;
				if (step_y) cy_q <= sy_neg_q ? cy_q - 10'sd1 : cy_q + 10'sd1;
			end else if (k_q != 3'd7) begin
				k_q <= k_q + 3'd1;
			end else begin
				k_q   <= '0;
				ox_q  <= ox_q + 10'sd1;
				if (!f_q[11]) oy_q <= oy_q - 10'sd1;
				ddy_q <= ddy_n;
				ddx_q <= ddx_q + 12'sd2;
				f_q   <= f_mid + ddx_q + 12'sd2;
			end
		end
	end

	assign busy      = init_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

### tb/tb_monochrome_framebuffer_rasterizer.sv
`timescale 1ns / 1ps
module tb_monochrome_framebuffer_rasterizer;

	localparam int PW = 84;
	localparam int PH = 48;
	localparam int BANDS = (PH + mfr_pkg::BAND_ROWS - 1) / mfr_pkg::BAND_ROWS;
	localparam int LIMIT = 4000000;
	localparam int CMD_W = $bits(mfr_pkg::cmd_t);

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	mfr_pkg::cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	mfr_pkg::rsp_t rsp;

	monochrome_framebuffer_rasterizer uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	logic [7:0] panel_bytes [PW*BANDS];
	int dl, dr, dt, db;
	mfr_pkg::rsp_t expected_rsps[$];
	int mismatches;
	int cycles;
	int cmds_sent;
	int rsps_seen;
	bit idle_on;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void set_pixel(int x, int y, bit c);
		int idx;
		if (x < 0 || y < 0 || x >= PW || y >= PH) return;
		idx = x + (y / mfr_pkg::BAND_ROWS) * PW;
		panel_bytes[idx][y % mfr_pkg::BAND_ROWS] = c;
		if (x < dl) dl = x;
		if (x > dr) dr = x;
		if (y < dt) dt = y;
		if (y > db) db = y;
	endfunction

	function automatic void empty_dirty();
		dl = PW - 1; dr = 0; dt = PH - 1; db = 0;
	endfunction

	function automatic mfr_pkg::rsp_t dirty_rsp(logic [7:0] v);
		mfr_pkg::rsp_t r;
		r.byte_value = v;
		r.dirty_left = dl[6:0];
		r.dirty_right = dr[6:0];
		r.dirty_top = dt[5:0];
		r.dirty_bottom = db[5:0];
		return r;
	endfunction

	function automatic void rasterize(mfr_pkg::cmd_t c);
		int x0, y0, x1, y1, dx, dy, sx, sy, err, e2;
		int f, ddx, ddy, cx, cy, px, py;
		logic [7:0] v;
		case (c.opcode)
			mfr_pkg::OP_PIXEL: set_pixel(c.x_start, c.y_start, c.color);
			mfr_pkg::OP_LINE: begin
				x0 = c.x_start; y0 = c.y_start; x1 = c.x_end; y1 = c.y_end;
				dx = x1 > x0 ? x1 - x0 : x0 - x1;
				dy = y1 > y0 ? y0 - y1 : y1 - y0;
				sx = x0 < x1 ? 1 : -1;
				sy = y0 < y1 ? 1 : -1;
				err = dx + dy;
				forever begin
					set_pixel(x0, y0, c.color);
					if (x0 == x1 && y0 == y1) break;
					e2 = 2 * err;
					if (e2 >= dy) begin err += dy; x0 += sx; end
					if (e2 <= dx) begin err += dx; y0 += sy; end
				end
			end
			mfr_pkg::OP_CIRCLE: begin
				cx = c.x_start; cy = c.y_start;
				px = 0; py = c.radius;
				f = 1 - py; ddx = 1; ddy = -2 * py;
				set_pixel(cx, cy + py, c.color);
				set_pixel(cx, cy - py, c.color);
				set_pixel(cx + py, cy, c.color);
				set_pixel(cx - py, cy, c.color);
				while (px < py) begin
					if (f >= 0) begin py--; ddy += 2; f += ddy; end
					px++; ddx += 2; f += ddx;
					set_pixel(cx + px, cy + py, c.color);
					set_pixel(cx - px, cy + py, c.color);
					set_pixel(cx + px, cy - py, c.color);
					set_pixel(cx - px, cy - py, c.color);
					set_pixel(cx + py, cy + px, c.color);
					set_pixel(cx - py, cy + px, c.color);
					set_pixel(cx + py, cy - px, c.color);
					set_pixel(cx - py, cy - px, c.color);
				end
			end
			mfr_pkg::OP_CLEAR: begin
				foreach (panel_bytes[i]) panel_bytes[i] = '0;
				dl = 0; dr = PW - 1; dt = 0; db = PH - 1;
			end
			mfr_pkg::OP_READ: begin
				v = '0;
				if (c.x_start < PW && c.y_start < PH)
					v = panel_bytes[c.x_start + (c.y_start / mfr_pkg::BAND_ROWS) * PW];
				expected_rsps.push_back(dirty_rsp(v));
			end
			mfr_pkg::OP_FETCH: begin
				expected_rsps.push_back(dirty_rsp('0));
				empty_dirty();
			end
			default: ;
		endcase
	endfunction

	// result side: random stall and checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsps_seen <= rsps_seen + 1;
				if (expected_rsps.size() == 0) begin
					mismatches <= mismatches + 1;
					$display("%0t: expected no result, actual %h", $time, rsp);
				end else begin
					automatic mfr_pkg::rsp_t e = expected_rsps.pop_front();
					if (e.byte_value !== rsp.byte_value)
						$display("%0t: byte_value expected %h actual %h", $time,
							e.byte_value, rsp.byte_value);
					if (e.dirty_left !== rsp.dirty_left)
						$display("%0t: dirty_left expected %0d actual %0d", $time,
							e.dirty_left, rsp.dirty_left);
					if (e.dirty_right !== rsp.dirty_right)
						$display("%0t: dirty_right expected %0d actual %0d", $time,
							e.dirty_right, rsp.dirty_right);
					if (e.dirty_top !== rsp.dirty_top)
						$display("%0t: dirty_top expected %0d actual %0d", $time,
							e.dirty_top, rsp.dirty_top);
					if (e.dirty_bottom !== rsp.dirty_bottom)
						$display("%0t: dirty_bottom expected %0d actual %0d", $time,
							e.dirty_bottom, rsp.dirty_bottom);
					if (e !== rsp) mismatches <= mismatches + 1;
				end
			end
			rsp_stall <= idle_on && ($urandom_range(99) < 19);
		end
	end

	// valid stays high after a beat so the next send needs no second assignment in one step
	task automatic send_cmd(mfr_pkg::cmd_t c);
		while (idle_on && $urandom_range(99) < 19) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		rasterize(c);
		cmds_sent++;
	endtask

	function automatic mfr_pkg::cmd_t make_cmd(logic [2:0] op, int xs, int ys, int xe, int ye,
			int r, bit c);
		mfr_pkg::cmd_t m;
		m.opcode = op;
		m.x_start = 8'(xs); m.y_start = 8'(ys); m.x_end = 8'(xe); m.y_end = 8'(ye);
		m.radius = 7'(r); m.color = c;
		return m;
	endfunction

	function automatic mfr_pkg::cmd_t rand_cmd();
		mfr_pkg::cmd_t m;
		int pick;
		m = CMD_W'({$urandom, $urandom});
		pick = $urandom_range(99);
		// mostly on-panel coordinates with short reach, sometimes anything
		if (pick < 85) begin
			m.x_start = 8'($urandom_range(PW + 8));
			m.y_start = 8'($urandom_range(PH + 8));
			m.x_end = 8'($urandom_range(PW + 8));
			m.y_end = 8'($urandom_range(PH + 8));
			m.radius = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
				: 7'($urandom_range(20));
		end
		pick = $urandom_range(99);
		if (pick < 22) m.opcode = mfr_pkg::OP_PIXEL;
		else if (pick < 37) m.opcode = mfr_pkg::OP_LINE;
		else if (pick < 47) m.opcode = mfr_pkg::OP_CIRCLE;
		else if (pick < 49) m.opcode = mfr_pkg::OP_CLEAR;
		else if (pick < 82) m.opcode = mfr_pkg::OP_READ;
		else if (pick < 96) m.opcode = mfr_pkg::OP_FETCH;
		else m.opcode = 3'($urandom_range(7, 6));
		return m;
	endfunction

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsps.size() != 0) @(posedge clk);
	endtask

	task automatic test_pixels_and_reads();
		send_cmd(make_cmd(mfr_pkg::OP_FETCH, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_PIXEL, PW - 1, PH - 1, 255, 255, 127, 1));
		send_cmd(make_cmd(mfr_pkg::OP_PIXEL, 255, 255, 0, 0, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_PIXEL, PW, 3, 0, 0, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_READ, PW - 1, PH - 1, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_READ, 255, 255, 255, 255, 127, 1));
		send_cmd(make_cmd(mfr_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_READ, 0, 7, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_FETCH, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_FETCH, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_lines_and_circles();
		send_cmd(make_cmd(mfr_pkg::OP_LINE, 0, 0, PW - 1, PH - 1, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_LINE, 70, 40, 5, 2, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_LINE, 10, 47, 12, 0, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_LINE, 90, 60, 90, 60, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_CIRCLE, 40, 20, 0, 0, 0, 1));
		send_cmd(make_cmd(mfr_pkg::OP_CIRCLE, 2, 3, 0, 0, 10, 1));
		send_cmd(make_cmd(mfr_pkg::OP_CIRCLE, 42, 24, 0, 0, 15, 0));
		send_cmd(make_cmd(mfr_pkg::OP_READ, 40, 20, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_FETCH, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(mfr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1));
		send_cmd(make_cmd(3'd6, 1, 1, 1, 1, 1, 1));
		send_cmd(make_cmd(3'd7, 2, 2, 2, 2, 2, 0));
		send_cmd(make_cmd(mfr_pkg::OP_FETCH, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_mix(int n);
		for (int i = 0; i < n; i++) begin
			idle_on = !(i >= 150 && i < 250);
			send_cmd(rand_cmd());
			if (i == 300) wait_drained();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		mismatches = 0;
		cycles = 0;
		cmds_sent = 0;
		rsps_seen = 0;
		idle_on = 1'b1;
		foreach (panel_bytes[i]) panel_bytes[i] = '0;
		empty_dirty();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixels_and_reads();
		test_lines_and_circles();
		test_random_mix(480);
		wait_drained();
		repeat (200) @(posedge clk);
		$display("sent %0d commands (pixel, line, circle, clear, read, fetch, unused)",
			cmds_sent);
		$display("checked %0d read/fetch results against the predicted panel", rsps_seen);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
